### sv/pmss_pkg.sv
package pmss_pkg;

    localparam int unsigned COUNT_W  = 16;
    localparam int unsigned SHOWN_W  = 14;
    localparam int unsigned DIGIT_W  = 4;
    localparam int unsigned SEG_W    = 7;
    localparam int unsigned IN_TDATA_W  = 8;
    localparam int unsigned OUT_TDATA_W = 48;

    localparam logic [COUNT_W-1:0] START_COUNT_RESET = 16'd512;
    localparam logic [COUNT_W-1:0] DISPLAY_MAX       = 16'd9999;

    // reciprocals, exact for every value up to DISPLAY_MAX
    localparam logic [14:0] RECIP_1000 = 15'd16778;   // 2^24 / 1000, rounded up
    localparam int unsigned SHIFT_1000 = 24;
    localparam logic [13:0] RECIP_100  = 14'd10486;   // 2^20 / 100, rounded up
    localparam int unsigned SHIFT_100  = 20;
    localparam logic [13:0] RECIP_10   = 14'd13108;   // 2^17 / 10, rounded up
    localparam int unsigned SHIFT_10   = 17;

    typedef logic [SEG_W-1:0] seg_t;

    // segment a in bit 0 up to segment g in bit 6
    function automatic seg_t seg_encode(input logic [DIGIT_W-1:0] digit);
        seg_t code;
        case (digit)
            4'd0:    code = 7'h3F;
            4'd1:    code = 7'h06;
            4'd2:    code = 7'h5B;
            4'd3:    code = 7'h4F;
            4'd4:    code = 7'h66;
            4'd5:    code = 7'h6D;
            4'd6:    code = 7'h7D;
            4'd7:    code = 7'h07;
            4'd8:    code = 7'h7F;
            4'd9:    code = 7'h6F;
            default: code = 7'h00;
        endcase
        return code;
    endfunction

endpackage

### sv/period_meter_seven_segment.sv
// channel   direction  signals                     content
// s_axis    in         tvalid tready tdata[7:0]    one pulse level sample per transaction
// m_axis    out        tvalid tready tdata[47:0]   count, four segment codes, over-range
// cfg       in         valid ready data[15:0]      start_count preload
//
// one sample is taken every cycle while s_axis_tready is high; the edge detector
// and period counter update in the cycle of the transaction.
// after its closing edge, a measured period passes through the count register,
// the reciprocal multiply register and the digit and segment output register.
// reset puts the detector in the wait phase with the previous level taken as high.
// the three stages each hold a result; s_axis stalls only when all three are full
// and m_axis_tready is low.
module period_meter_seven_segment
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [pmss_pkg::IN_TDATA_W-1:0]    s_axis_tdata,   // [0] pulse_level
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [15:0] period_count, [22:16] seg_units, [29:23] seg_tens,
    // [36:30] seg_hundreds, [43:37] seg_thousands, [44] over_range
    output logic [pmss_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [pmss_pkg::COUNT_W-1:0]       cfg_data
);

    logic [pmss_pkg::COUNT_W-1:0] start_count_reg;
    logic                         phase_reg;
    logic                         phase_next;
    logic                         last_level_reg;
    logic [pmss_pkg::COUNT_W-1:0] tick_count_reg;
    logic [pmss_pkg::COUNT_W-1:0] tick_count_next;

    logic                         s1_valid_reg;
    logic                         s1_valid_next;
    logic [pmss_pkg::COUNT_W-1:0] s1_count_reg;

    logic                         s2_valid_reg;
    logic [pmss_pkg::COUNT_W-1:0] s2_count_reg;
    logic                         s2_over_reg;
    logic [pmss_pkg::SHOWN_W-1:0] s2_shown_reg;
    logic [3:0]                   s2_q1000_reg;
    logic [6:0]                   s2_q100_reg;
    logic [9:0]                   s2_q10_reg;

    logic                         s3_valid_reg;
    logic [pmss_pkg::OUT_TDATA_W-1:0] s3_data_reg;

    logic ready1, ready2, ready3;
    logic in_accept;
    logic level;
    logic edge_seen;
    logic [pmss_pkg::COUNT_W-1:0] count_inc;

    logic                         over_c;
    logic [pmss_pkg::SHOWN_W-1:0] shown_c;
    logic [28:0]                  prod1000;
    logic [27:0]                  prod100;
    logic [27:0]                  prod10;

    logic [3:0] dig_units, dig_tens, dig_hund;
    pmss_pkg::seg_t seg_units, seg_tens, seg_hund, seg_thou;

    // stage handshake: a stage takes new data when empty or when it drains
    assign ready3 = ~s3_valid_reg | m_axis_tready;
    assign ready2 = ~s2_valid_reg | ready3;
    assign ready1 = ~s1_valid_reg | ready2;

    assign s_axis_tready = ready1;
    assign in_accept     = s_axis_tvalid & s_axis_tready;
    assign cfg_ready     = 1'b1;

    assign m_axis_tvalid = s3_valid_reg;
    assign m_axis_tdata  = s3_data_reg;

    // edge detection and period counter
    assign level     = s_axis_tdata[0];
    assign edge_seen = level & ~last_level_reg;
    assign count_inc = tick_count_reg + 16'd1;

    always_comb
    begin
        phase_next      = phase_reg;
        tick_count_next = tick_count_reg;
        s1_valid_next   = s1_valid_reg & ~ready2;
        if (in_accept)
        begin
            s1_valid_next = 1'b0;
            if (!phase_reg)
            begin
                if (edge_seen)
                begin
                    tick_count_next = start_count_reg;
                    phase_next      = 1'b1;
                end
            end
            else
            begin
                tick_count_next = count_inc;
                if (edge_seen)
                begin
                    phase_next    = 1'b0;
                    s1_valid_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_count_reg <= pmss_pkg::START_COUNT_RESET;
            phase_reg       <= 1'b0;
            last_level_reg  <= 1'b1;
            tick_count_reg  <= '0;
            s1_valid_reg    <= 1'b0;
            s2_valid_reg    <= 1'b0;
            s3_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                start_count_reg <= cfg_data;
            end
            if (in_accept)
            begin
                last_level_reg <= level;
            end
            phase_reg      <= phase_next;
            tick_count_reg <= tick_count_next;
            s1_valid_reg   <= s1_valid_next;
            if (ready2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (ready3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    // stage 1 payload: the reported count
    always_ff @(posedge clk)
    begin
        if (in_accept && phase_reg && edge_seen)
        begin
            s1_count_reg <= count_inc;
        end
    end

    // stage 2: saturate and take quotients by reciprocal multiply
    assign over_c   = (s1_count_reg > pmss_pkg::DISPLAY_MAX);
    assign shown_c  = over_c ? pmss_pkg::DISPLAY_MAX[pmss_pkg::SHOWN_W-1:0]
                             : s1_count_reg[pmss_pkg::SHOWN_W-1:0];
    assign prod1000 = {15'd0, shown_c} * {14'd0, pmss_pkg::RECIP_1000};
    assign prod100  = {14'd0, shown_c} * {14'd0, pmss_pkg::RECIP_100};
    assign prod10   = {14'd0, shown_c} * {14'd0, pmss_pkg::RECIP_10};

    always_ff @(posedge clk)
    begin
        if (ready2 && s1_valid_reg)
        begin
            s2_count_reg <= s1_count_reg;
            s2_over_reg  <= over_c;
            s2_shown_reg <= shown_c;
            s2_q1000_reg <= prod1000[pmss_pkg::SHIFT_1000 +: 4];
            s2_q100_reg  <= prod100[pmss_pkg::SHIFT_100 +: 7];
            s2_q10_reg   <= prod10[pmss_pkg::SHIFT_10 +: 10];
        end
    end

    // stage 3: lower digits: a quotient minus ten times the next quotient, low bits only
    assign dig_units = s2_shown_reg[3:0]
                     - ({s2_q10_reg[0], 3'b000} + {s2_q10_reg[2:0], 1'b0});
    assign dig_tens  = s2_q10_reg[3:0]
                     - ({s2_q100_reg[0], 3'b000} + {s2_q100_reg[2:0], 1'b0});
    assign dig_hund  = s2_q100_reg[3:0]
                     - ({s2_q1000_reg[0], 3'b000} + {s2_q1000_reg[2:0], 1'b0});

    assign seg_units = pmss_pkg::seg_encode(dig_units);
    assign seg_tens  = pmss_pkg::seg_encode(dig_tens);
    assign seg_hund  = pmss_pkg::seg_encode(dig_hund);
    assign seg_thou  = pmss_pkg::seg_encode(s2_q1000_reg);

    always_ff @(posedge clk)
    begin
        if (ready3 && s2_valid_reg)
        begin
            s3_data_reg <= {3'b000, s2_over_reg, seg_thou, seg_hund, seg_tens, seg_units,
                            s2_count_reg};
        end
    end

endmodule

### verif/period_meter_seven_segment_test.sv
`timescale 1ns / 1ps

module period_meter_seven_segment_test;

    localparam int unsigned SAMPLE_TARGET = 1550;
    localparam int unsigned MAX_GAP       = 18;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int unsigned REPORT_LIMIT  = 10;
    localparam logic [pmss_pkg::COUNT_W-1:0] PRELOAD_MAX = 16'hFFFF;

    // segment codes for digits 9 down to 0, digit d at bits [7d +: 7]
    localparam logic [69:0] SEGMENT_TABLE = {
        7'h6F, 7'h7F, 7'h07, 7'h7D, 7'h6D, 7'h66, 7'h4F, 7'h5B, 7'h06, 7'h3F
    };

    typedef logic [pmss_pkg::COUNT_W-1:0] count_t;

    typedef struct {
        count_t         count;
        pmss_pkg::seg_t units;
        pmss_pkg::seg_t tens;
        pmss_pkg::seg_t hundreds;
        pmss_pkg::seg_t thousands;
        logic           over;
    } period_reading_t;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [pmss_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;   // [0] pulse_level
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    // [15:0] period_count, [22:16] seg_units, [29:23] seg_tens,
    // [36:30] seg_hundreds, [43:37] seg_thousands, [44] over_range
    logic [pmss_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    count_t                           cfg_data = '0;

    // predictor state
    bit     measuring = 1'b0;
    bit     prev_level = 1'b1;
    count_t period_ticks = '0;
    count_t preload = pmss_pkg::START_COUNT_RESET;

    period_reading_t pending_periods[$];

    int unsigned samples_sent = 0;
    int unsigned periods_checked = 0;
    int unsigned preload_writes = 0;
    int unsigned mismatches = 0;
    int unsigned unexpected = 0;
    int unsigned cycles = 0;
    bit          no_idle = 1'b0;

    period_meter_seven_segment DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic pmss_pkg::seg_t segments_of(input int unsigned value);
        return SEGMENT_TABLE[(value % 10) * 7 +: 7];
    endfunction

    task automatic measure_sample(input logic level);
        logic            rising;
        int unsigned     shown;
        period_reading_t reading;
        rising = level && !prev_level;
        prev_level = level;
        if (!measuring)
        begin
            if (rising)
            begin
                period_ticks = preload;
                measuring = 1'b1;
            end
        end
        else
        begin
            period_ticks = period_ticks + 1'b1;
            if (rising)
            begin
                shown = (period_ticks > pmss_pkg::DISPLAY_MAX) ? 32'(pmss_pkg::DISPLAY_MAX)
                                                               : 32'(period_ticks);
                reading.count     = period_ticks;
                reading.units     = segments_of(shown);
                reading.tens      = segments_of(shown / 10);
                reading.hundreds  = segments_of(shown / 100);
                reading.thousands = segments_of(shown / 1000);
                reading.over      = (period_ticks > pmss_pkg::DISPLAY_MAX);
                pending_periods.push_back(reading);
                // the closing edge does not open a new measurement
                measuring = 1'b0;
            end
        end
    endtask

    task automatic send_level(input logic level);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(pmss_pkg::IN_TDATA_W-1){1'b0}}, level};
        do @(posedge clk); while (!s_axis_tready);
        measure_sample(level);
        samples_sent++;
    endtask

    // levels sent from the highest used bit down
    task automatic send_pattern(input logic [15:0] levels, input int n);
        for (int i = n - 1; i >= 0; i--)
            send_level(levels[i]);
    endtask

    task automatic hold_until_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_periods.size() != 0) @(posedge clk);
    endtask

    task automatic settle();
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_preload(input count_t value);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        preload = value;
        preload_writes++;
    endtask

    // a high level right after reset must not count as an edge
    task automatic test_high_at_reset();
        send_pattern(16'b101001, 6);
    endtask

    // after a report the next edge only arms, the one after it reports
    task automatic test_rearm_after_report();
        send_pattern(16'b0101, 4);
    endtask

    task automatic test_counter_wrap();
        write_preload(PRELOAD_MAX - 1'b1);
        send_pattern(16'b0101, 4);
        write_preload(PRELOAD_MAX);
        send_pattern(16'b0101, 4);
    endtask

    // 9999 still shown, 10000 saturates the digits
    task automatic test_display_limit();
        write_preload(pmss_pkg::DISPLAY_MAX - 2'd2);
        send_pattern(16'b0101, 4);
        send_pattern(16'b01001, 5);
    endtask

    task automatic test_random_periods();
        int unsigned phase_end;
        while (samples_sent < SAMPLE_TARGET)
        begin
            case ($urandom_range(0, 5))
                0:       write_preload('0);
                1:       write_preload(PRELOAD_MAX);
                2:       write_preload(count_t'(pmss_pkg::DISPLAY_MAX - $urandom_range(0, 12)));
                3:       write_preload(count_t'($urandom_range(0, pmss_pkg::DISPLAY_MAX)));
                4:       write_preload(count_t'(PRELOAD_MAX - $urandom_range(0, 40)));
                default: write_preload(count_t'($urandom()));
            endcase
            no_idle = ($urandom_range(0, 3) == 0);
            phase_end = samples_sent + $urandom_range(40, 140);
            if (phase_end > SAMPLE_TARGET)
                phase_end = SAMPLE_TARGET;
            while (samples_sent < phase_end)
            begin
                if ($urandom_range(0, 7) == 0)
                begin
                    // noise
                    repeat ($urandom_range(1, 10)) send_level(1'($urandom_range(0, 1)));
                end
                else
                begin
                    // arm, then high and low stretches, then the closing edge
                    repeat ($urandom_range(1, 6)) send_level(1'b0);
                    send_level(1'b1);
                    repeat ($urandom_range(0, 4)) send_level(1'b1);
                    repeat ($urandom_range(1, 8)) send_level(1'b0);
                    send_level(1'b1);
                end
                if ($urandom_range(0, 24) == 0)
                    hold_until_drained();
            end
        end
        no_idle = 1'b0;
    endtask

    // result sink with random stalls
    initial
    begin
        int unsigned stall;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    always @(posedge clk)
    begin
        period_reading_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_periods.size() == 0)
            begin
                unexpected++;
                if (mismatches + unexpected <= REPORT_LIMIT)
                    $display("unexpected period transaction: data %h", m_axis_tdata);
            end
            else
            begin
                want = pending_periods.pop_front();
                periods_checked++;
                if (m_axis_tdata[15:0]  !== want.count    ||
                    m_axis_tdata[22:16] !== want.units    ||
                    m_axis_tdata[29:23] !== want.tens     ||
                    m_axis_tdata[36:30] !== want.hundreds ||
                    m_axis_tdata[43:37] !== want.thousands ||
                    m_axis_tdata[44]    !== want.over)
                begin
                    mismatches++;
                    if (mismatches + unexpected <= REPORT_LIMIT)
                        $display("period mismatch: expected count %0d seg %h %h %h %h over %0d",
                                 want.count, want.thousands, want.hundreds, want.tens,
                                 want.units, want.over, "; got count %0d seg %h %h %h %h over %0d",
                                 m_axis_tdata[15:0], m_axis_tdata[43:37], m_axis_tdata[36:30],
                                 m_axis_tdata[29:23], m_axis_tdata[22:16], m_axis_tdata[44]);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d periods still awaited",
                     cycles, pending_periods.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        int unsigned errors;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_high_at_reset();
        test_rearm_after_report();
        test_counter_wrap();
        test_display_limit();
        test_random_periods();
        settle();
        errors = mismatches + unexpected + pending_periods.size();
        $display("%0d pulse samples sent, %0d measured periods checked", samples_sent,
                 periods_checked);
        $display("%0d preload settings including wrap and display limit cases, %0d errors",
                 preload_writes, errors);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
